/* rtl/b64e_pkg.sv */
// Shared types, constants and the sextet-to-ASCII mapping for the Base64 encoder.
package b64e_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CharW   = 7;
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  localparam logic [CharW-1:0] PadChar = 7'd61;  // '='

  // One completed 3-byte group, zero-filled, with its real byte count (1..3).
  typedef struct packed {
    logic [ByteW-1:0] g0;
    logic [ByteW-1:0] g1;
    logic [ByteW-1:0] g2;
    logic [1:0]       nbytes;
    logic             last;
  } grp_t;

  // Front to queue: write strobe and the group.
  typedef struct packed {
    logic push;
    grp_t grp;
  } push_t;

  // Queue to back: head entry and pop strobe go separately (pop flows back).
  typedef struct packed {
    logic valid;
    grp_t grp;
  } head_t;

  // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
  function automatic logic [CharW-1:0] b64_sym(input logic [5:0] six);
    logic [CharW-1:0] v;
    v = {1'b0, six};
    if (six < 6'd26) begin
      b64_sym = v + 7'd65;
    end else if (six < 6'd52) begin
      b64_sym = v + 7'd71;   // 'a' - 26
    end else if (six < 6'd62) begin
      b64_sym = v - 7'd4;    // '0' - 52
    end else if (six == 6'd62) begin
      b64_sym = 7'd43;       // '+'
    end else begin
      b64_sym = 7'd47;       // '/'
    end
  endfunction

endpackage

/* rtl/base64_stream_encoder.sv */
// Top level of the streaming Base64 encoder (standard alphabet, '=' padding).
//
// Slave channel: one raw byte per item on s_axis_tdata, s_axis_tlast marks
// the final byte of a message. Master channel: one ASCII character per item
// on m_axis_tdata[6:0] (bit 7 is zero), m_axis_tlast marks the final
// character of the encoded message.
// A third byte, or a byte with tlast, closes a group; the front end pushes
// the zero-filled group into a two-entry queue and the back end emits its
// four characters, one per cycle, through a registered output stage.
// The first character of a group passes through the queue entry, the back
// end's group register and the output register.
// Throughput: the back end emits one character per cycle while the receiver
// is ready, so a long message sustains four output items per three input
// items; bytes that only fill the pending slots are taken each cycle while
// the queue has room.
// When the receiver stalls, the output register holds its character, the
// back end stops, the queue fills and then s_axis_tready drops.
// Reset clears the pending count, the queue and the output valid; no
// message state survives reset.
module base64_stream_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // last_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [6:0] out_char, [7] zero
  output logic       m_axis_tlast    // last_char
);
  import b64e_pkg::*;

  push_t push;
  head_t head;
  logic  q_full;
  logic  pop;

  // Group assembly from incoming bytes
  b64e_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tlast_i  (s_axis_tlast),
    .q_full_i   (q_full),
    .push_o     (push)
  );

  // Decouples byte intake from character output
  b64e_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .head_o (head),
    .pop_i  (pop)
  );

  // Four characters per group, registered output
  b64e_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule

/* rtl/b64e_front.sv */
// Front end: collects input bytes into 3-byte groups and pushes finished groups.
module b64e_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_tvalid_i,
  output logic                    s_tready_o,
  input  logic [7:0]              s_tdata_i,
  input  logic                    s_tlast_i,
  input  logic                    q_full_i,
  output b64e_pkg::push_t         push_o
);
  import b64e_pkg::*;

  logic [ByteW-1:0] first_q, first_d;
  logic [ByteW-1:0] second_q, second_d;
  logic [1:0]       count_q, count_d;
  logic             accept;
  logic             have2;

  assign s_tready_o = !q_full_i;
  assign accept     = s_tvalid_i && s_tready_o;
  assign have2      = count_q[1];  // 2 pending (3 never occurs, acts as 2)

  always_comb begin
    first_d     = first_q;
    second_d    = second_q;
    count_d     = count_q;
    push_o      = '0;
    if (accept) begin
      if (!s_tlast_i && !have2) begin
        if (count_q == 2'd0) begin
          first_d = s_tdata_i;
        end else begin
          second_d = s_tdata_i;
        end
        count_d = count_q + 2'd1;
      end else begin
        push_o.push        = 1'b1;
        push_o.grp.last    = s_tlast_i;
        if (have2) begin
          push_o.grp.g0     = first_q;
          push_o.grp.g1     = second_q;
          push_o.grp.g2     = s_tdata_i;
          push_o.grp.nbytes = 2'd3;
        end else if (count_q == 2'd1) begin
          push_o.grp.g0     = first_q;
          push_o.grp.g1     = s_tdata_i;
          push_o.grp.nbytes = 2'd2;
        end else begin
          push_o.grp.g0     = s_tdata_i;
          push_o.grp.nbytes = 2'd1;
        end
        count_d = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q  <= first_d;
    second_q <= second_d;
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("pending count out of range");
  a_push_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.push |=> count_q == 2'd0) else $error("count not cleared after group");
`endif

endmodule

/* rtl/b64e_queue.sv */
// Two-entry group queue between the front end and the character emitter.
module b64e_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  b64e_pkg::push_t     push_i,
  output logic                full_o,
  output b64e_pkg::head_t     head_o,
  input  logic                pop_i
);
  import b64e_pkg::*;

  grp_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o       = (cnt_q == QCntW'(QDepth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.grp   = mem_q[rd_q];
  assign do_push      = push_i.push && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.grp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i.push && full_o)) else $error("push into full queue");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth)) else $error("queue count out of range");
`endif

endmodule

/* rtl/b64e_back.sv */
// Back end: turns one queued group into four characters, one per cycle while the output is free.
module b64e_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  b64e_pkg::head_t     head_i,
  output logic                pop_o,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic [7:0]          m_tdata_o,
  output logic                m_tlast_o
);
  import b64e_pkg::*;

  grp_t             grp_q;
  logic             busy_q, busy_d;
  logic [1:0]       idx_q, idx_d;
  logic             ov_q, ov_d;
  logic [CharW-1:0] oc_q, oc_d;
  logic             ol_q, ol_d;
  logic             out_free, emit, fin;
  logic [5:0]       six;
  logic [CharW-1:0] chr;

  assign out_free = !ov_q || m_tready_i;
  assign emit     = busy_q && out_free;
  assign fin      = emit && (idx_q == 2'd3);
  assign pop_o    = head_i.valid && (!busy_q || fin);

  always_comb begin
    case (idx_q)
      2'd0:    six = grp_q.g0[7:2];
      2'd1:    six = {grp_q.g0[1:0], grp_q.g1[7:4]};
      2'd2:    six = {grp_q.g1[3:0], grp_q.g2[7:6]};
      default: six = grp_q.g2[5:0];
    endcase
    chr = b64_sym(six);
    if ((idx_q == 2'd2 && grp_q.nbytes < 2'd2) || (idx_q == 2'd3 && grp_q.nbytes < 2'd3)) begin
      chr = PadChar;
    end
  end

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    ov_d   = ov_q && !m_tready_i;
    oc_d   = oc_q;
    ol_d   = ol_q;
    if (emit) begin
      ov_d  = 1'b1;
      oc_d  = chr;
      ol_d  = grp_q.last && (idx_q == 2'd3);
      idx_d = idx_q + 2'd1;
    end
    if (fin || !busy_q) begin
      busy_d = pop_o;
    end
    if (pop_o) begin
      idx_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      grp_q <= head_i.grp;
    end
    oc_q <= oc_d;
    ol_q <= ol_d;
  end

  assign m_tvalid_o = ov_q;
  assign m_tdata_o  = {1'b0, oc_q};
  assign m_tlast_o  = ol_q;

`ifndef NO_ASSERTIONS
  a_idle_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> idx_q == 2'd0) else $error("index not at zero while idle");
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && idx_q != 2'd3 |=> busy_q) else $error("group dropped before fourth char");
  a_pop_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> busy_q && idx_q == 2'd0) else $error("new group not started at char 0");
`endif

endmodule

/* verif/b64e_char_check.sv */
// Checker for the Base64 encoder: predicts the character stream and compares it.
module b64e_char_check (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  input  logic       s_tready_i,
  input  logic [7:0] s_tdata_i,   // [7:0] data_byte
  input  logic       s_tlast_i,   // last_byte
  input  logic       m_tvalid_i,
  input  logic       m_tready_i,
  input  logic [7:0] m_tdata_i,   // [6:0] out_char, [7] zero
  input  logic       m_tlast_i,   // last_char
  output int         mismatches_o,
  output int         chars_owed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import b64e_pkg::*;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             fin;
  } enc_char_t;

  // Index 0 sits in the top byte, so Alphabet[n] is the n-th symbol.
  localparam logic [0:63][7:0] Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic [7:0] held_first;
  logic [7:0] held_second;
  logic [1:0] held_cnt;
  enc_char_t  owed_chars[$];
  int         mismatches;

  assign mismatches_o = mismatches;
  assign chars_owed_o = owed_chars.size();

  task automatic flag_mismatch(input string msg);
    $display("%0t b64e check: %s", $time, msg);
    mismatches++;
  endtask

  function automatic logic [CharW-1:0] sym(input logic [5:0] six);
    logic [7:0] c;
    c = Alphabet[six];
    return c[CharW-1:0];
  endfunction

  // Takes one byte; a third byte or a final byte closes the group into 4 chars.
  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    logic [7:0] g0, g1, g2;
    int         nb;
    enc_char_t  e;
    if (!fin && held_cnt < 2) begin
      if (held_cnt == 0) held_first = b;
      else held_second = b;
      held_cnt = held_cnt + 2'd1;
      return;
    end
    nb = held_cnt + 1;
    g0 = (nb == 1) ? b : held_first;
    g1 = (nb == 1) ? 8'd0 : (nb == 2) ? b : held_second;
    g2 = (nb == 3) ? b : 8'd0;
    e.fin = 1'b0;
    e.ch = sym(g0[7:2]);
    owed_chars.push_back(e);
    e.ch = sym({g0[1:0], g1[7:4]});
    owed_chars.push_back(e);
    e.ch = (nb >= 2) ? sym({g1[3:0], g2[7:6]}) : PadChar;
    owed_chars.push_back(e);
    e.ch = (nb == 3) ? sym(g2[5:0]) : PadChar;
    e.fin = fin;
    owed_chars.push_back(e);
    held_first = 8'd0;
    held_second = 8'd0;
    held_cnt = 2'd0;
  endfunction

  initial mismatches = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    enc_char_t want;
    if (!rst_ni) begin
      held_first = 8'd0;
      held_second = 8'd0;
      held_cnt = 2'd0;
      owed_chars.delete();
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        encode_byte(s_tdata_i, s_tlast_i);
      end
      if (m_tvalid_i && m_tready_i) begin
        if (owed_chars.size() == 0) begin
          flag_mismatch($sformatf("unexpected char 0x%02h last %0d", m_tdata_i, m_tlast_i));
        end else begin
          want = owed_chars.pop_front();
          if (m_tdata_i[CharW-1:0] !== want.ch)
            flag_mismatch($sformatf("char 0x%02h, want 0x%02h", m_tdata_i[CharW-1:0], want.ch));
          if (m_tdata_i[7] !== 1'b0)
            flag_mismatch("tdata bit 7 not zero");
          if (m_tlast_i !== want.fin)
            flag_mismatch($sformatf("tlast %0d, want %0d", m_tlast_i, want.fin));
        end
      end
    end
  end

endmodule

/* verif/base64_stream_encoder_test.sv */
// Testbench top for the Base64 encoder: stimulus, stall patterns and the verdict.
module base64_stream_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  int         mismatches;
  int         chars_owed;

  // Calm stretches: no gaps on that side while set.
  logic       tx_calm;
  logic       rx_calm;
  int         bytes_sent;

  base64_stream_encoder uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  b64e_char_check chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tlast_i   (s_axis_tlast),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tlast_i   (m_axis_tlast),
    .mismatches_o(mismatches),
    .chars_owed_o(chars_owed)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Hard stop well beyond the slowest legal run (all gaps and stalls at max).
  initial begin
    #1000000;
    $display("base64_stream_encoder_test: done, errors");
    $finish;
  end

  // Sends one item; called right after a rising edge, returns after the edge
  // that accepted it. Valid only drops when a gap is drawn.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    if ($urandom_range(0, 15) == 0) tx_calm = ~tx_calm;
  endtask

  // Holds the sender idle until every owed char has been taken; the first
  // edge lets the checker count the group closed at the accepting edge.
  task automatic drain_chars();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (chars_owed != 0) @(posedge clk_i);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  // Receiver: random stall before each char, with calm stretches.
  initial begin
    int stall;
    rx_calm = 1'b0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if ($urandom_range(0, 15) == 0) rx_calm = ~rx_calm;
    end
  end

  initial begin
    bit paused;
    int len;
    tx_calm = 1'b0;
    bytes_sent = 0;
    paused = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'd0;
    s_axis_tlast  <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: one-byte and two-byte final groups at the byte extremes,
    // full final groups, then a full group without the flag ("++++")
    // followed by a short tail.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'h83, 1'b0);
    send_byte(8'h7F, 1'b1);
    drain_chars();

    // Random messages, mostly short, now and then a long one.
    while (bytes_sent < 295) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      send_message(len);
      if (!paused && bytes_sent > 170) begin
        drain_chars();
        paused = 1'b1;
      end
    end
    drain_chars();

    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && chars_owed == 0) begin
      $display("base64_stream_encoder_test: done, clean");
    end else begin
      $display("base64_stream_encoder_test: done, errors");
    end
    $finish;
  end

endmodule

/* base64_stream_encoder.f */
rtl/b64e_pkg.sv
rtl/b64e_front.sv
rtl/b64e_queue.sv
rtl/b64e_back.sv
rtl/base64_stream_encoder.sv
verif/b64e_char_check.sv
verif/base64_stream_encoder_test.sv
